// ----- src/assert_macros.svh -----
// assertion macros for the ring lookup checker
// no dependencies; included by the checker file only
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define CHRL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("chrl: assertion failed");

// next-cycle implication under reset
`define CHRL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("chrl: assertion failed");

`endif

// ----- src/chrl_pkg.sv -----
// shared types and constants for the consistent hash ring lookup
// no dependencies; used by the top level and the checker
`default_nettype none

package chrl_pkg;

  // default sizes
  localparam int unsigned MAX_NODES_DEF = 16;
  localparam int unsigned HASH_BITS_DEF = 64;
  localparam int unsigned TAG_BITS_DEF  = 8;

  // input transaction layout
  localparam int unsigned IN_HASH_W = 64;
  localparam int unsigned IN_TAG_W  = 8;
  localparam int unsigned IN_DATA_W = IN_HASH_W + IN_TAG_W;
  localparam int unsigned IN_USER_W = 1;

  // output transaction layout
  localparam int unsigned OUT_STATUS_W = 2;
  localparam int unsigned OUT_OWNER_W  = 8;
  localparam int unsigned OUT_COUNT_W  = 5;
  localparam int unsigned OUT_USED_W   = OUT_STATUS_W + OUT_OWNER_W + OUT_COUNT_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;
  localparam int unsigned OUT_OWNER_LO = OUT_STATUS_W;
  localparam int unsigned OUT_COUNT_LO = OUT_STATUS_W + OUT_OWNER_W;

  // opcodes
  localparam logic OP_JOIN   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // result status codes
  localparam logic [OUT_STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [OUT_STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [OUT_STATUS_W-1:0] STAT_FULL  = 2'd2;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_JOIN,
    ST_FIN
  } chrl_state_e;

endpackage

`default_nettype wire

// ----- src/chrl_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module chrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/consistent_hash_ring_lookup.sv -----
// consistent hash ring: sorted node table with join and successor lookup
// depends on chrl_pkg and chrl_ram
`default_nettype none

// Usage
//   input stream (s_axis_*): one transaction per request. tuser carries the
//   opcode (join or lookup), tdata the hash and, for a join, the node tag.
//   output stream (m_axis_*): exactly one transaction per request, carrying
//   status, owner tag and the node count after the request.
//   The node table lives in one ram of MAX_NODES (hash, tag) words kept in
//   ascending hash order. A lookup walks the table upwards from entry 0 and
//   stops at the first hash not below the key; a join walks downwards from
//   the top, moving each larger-or-equal entry up one slot, then writes the
//   new node into the gap. The ram port gives one entry per cycle. Full
//   joins and empty lookups go from idle straight to the final state
//   without a ram access. s_axis_tready is high only while the sequencer
//   is idle, so one request is in flight at a time; the next one can be
//   taken once its result has been moved to the output register. The
//   result waits there; a new request is taken while it waits, and a
//   finished request holds in the final state until the receiver has
//   taken the previous result. Reset empties the ring (node count zero);
//   table contents are not cleared and need no clearing pass.

module consistent_hash_ring_lookup #(
  parameter int unsigned MAX_NODES = chrl_pkg::MAX_NODES_DEF,
  parameter int unsigned HASH_BITS = chrl_pkg::HASH_BITS_DEF,
  parameter int unsigned TAG_BITS  = chrl_pkg::TAG_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // hash_value [63:0], node_tag [71:64]
  input  logic [chrl_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // opcode [0]
  input  logic [chrl_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status [1:0], owner_tag [9:2], node_count [14:10], zero [15]
  output logic [chrl_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  import chrl_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_NODES);
  localparam int unsigned CNT_W  = $clog2(MAX_NODES + 1);
  localparam int unsigned WORD_W = HASH_BITS + TAG_BITS;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NODES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  chrl_state_e state_q, state_d;

  logic [CNT_W-1:0]        count_q, count_d;    // entries in the ring
  logic [CNT_W-1:0]        idx_q, idx_d;        // lookup: next read; join: gap slot
  logic                    pend_q, pend_d;      // ram read issued last cycle
  logic [TAG_BITS-1:0]     wrap_q, wrap_d;      // tag of entry 0 for wrap-around
  logic [OUT_STATUS_W-1:0] res_status_q, res_status_d;
  logic [TAG_BITS-1:0]     res_owner_q, res_owner_d;

  // request payload
  logic [HASH_BITS-1:0]    hash_q;
  logic [TAG_BITS-1:0]     tag_q;

  // output register
  logic                    out_valid_q, out_valid_d;
  logic [OUT_STATUS_W-1:0] out_status_q, out_status_d;
  logic [OUT_OWNER_W-1:0]  out_owner_q, out_owner_d;
  logic [OUT_COUNT_W-1:0]  out_count_q, out_count_d;

  // ram port
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [WORD_W-1:0]       ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic [WORD_W-1:0]       ram_rdata;

  logic [HASH_BITS-1:0]    rd_hash;
  logic [TAG_BITS-1:0]     rd_tag;
  logic                    rd_hit;
  logic                    in_accept;

  assign rd_hash   = ram_rdata[HASH_BITS-1:0];
  assign rd_tag    = ram_rdata[WORD_W-1:HASH_BITS];
  assign rd_hit    = (rd_hash >= hash_q);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  chrl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_NODES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    wrap_d       = wrap_q;
    res_status_d = res_status_q;
    res_owner_d  = res_owner_q;
    out_status_d = out_status_q;
    out_owner_d  = out_owner_q;
    out_count_d  = out_count_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    ram_we       = 1'b0;
    ram_waddr    = idx_q[IDX_W-1:0];
    ram_wdata    = {tag_q, hash_q};
    ram_raddr    = idx_q[IDX_W-1:0];
    s_axis_tready = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          pend_d       = 1'b0;
          res_owner_d  = '0;
          res_status_d = STAT_OK;
          if (s_axis_tuser[0] == OP_JOIN) begin
            if (count_q == CNT_MAX) begin
              res_status_d = STAT_FULL;
              state_d      = ST_FIN;
            end else begin
              idx_d   = count_q;
              state_d = ST_JOIN;
            end
          end else begin
            if (count_q == '0) begin
              res_status_d = STAT_EMPTY;
              state_d      = ST_FIN;
            end else begin
              idx_d   = '0;
              state_d = ST_LOOK;
            end
          end
        end
      end

      // walk upwards, one entry per cycle; the ram read data is registered, so it lags its address
      ST_LOOK: begin
        if (pend_q && rd_hit) begin
          res_owner_d = rd_tag;
          pend_d      = 1'b0;
          state_d     = ST_FIN;
        end else if (pend_q && (idx_q == count_q)) begin
          // key above every hash: wrap to the smallest entry
          res_owner_d = (idx_q == CNT_ONE) ? rd_tag : wrap_q;
          pend_d      = 1'b0;
          state_d     = ST_FIN;
        end else begin
          ram_raddr = idx_q[IDX_W-1:0];
          idx_d     = idx_q + CNT_ONE;
          pend_d    = 1'b1;
        end
        if (pend_q && (idx_q == CNT_ONE)) begin
          wrap_d = rd_tag;
        end
      end

      // walk downwards from the top, moving entries up into the gap
      ST_JOIN: begin
        if (!pend_q) begin
          if (idx_q == '0) begin
            ram_we    = 1'b1;
            count_d   = count_q + CNT_ONE;
            state_d   = ST_FIN;
          end else begin
            ram_raddr = IDX_W'(idx_q - CNT_ONE);
            pend_d    = 1'b1;
          end
        end else if (rd_hit) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          idx_d     = idx_q - CNT_ONE;
          if (idx_q > CNT_ONE) begin
            ram_raddr = IDX_W'(idx_q - CNT_W'(2));
            pend_d    = 1'b1;
          end else begin
            pend_d = 1'b0;
          end
        end else begin
          ram_we  = 1'b1;
          pend_d  = 1'b0;
          count_d = count_q + CNT_ONE;
          state_d = ST_FIN;
        end
      end

      // hand over to the output register once it is free
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_owner_d  = OUT_OWNER_W'(res_owner_q);
          out_count_d  = OUT_COUNT_W'(count_q);
          state_d      = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      hash_q <= s_axis_tdata[HASH_BITS-1:0];
      tag_q  <= TAG_BITS'(s_axis_tdata[IN_HASH_W +: IN_TAG_W]);
    end
    wrap_q       <= wrap_d;
    res_status_q <= res_status_d;
    res_owner_q  <= res_owner_d;
    out_status_q <= out_status_d;
    out_owner_q  <= out_owner_d;
    out_count_q  <= out_count_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_count_q, out_owner_q, out_status_q});

endmodule

`default_nettype wire

// ----- src/chrl_checker.sv -----
// port-level checker for the consistent hash ring lookup, bound to the top level
// depends on chrl_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module chrl_checker #(
  parameter int unsigned MAX_NODES = chrl_pkg::MAX_NODES_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [chrl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  import chrl_pkg::*;

  localparam logic [OUT_COUNT_W-1:0] FULL_CNT = OUT_COUNT_W'(MAX_NODES);

  logic [OUT_STATUS_W-1:0] status;
  logic [OUT_OWNER_W-1:0]  owner;
  logic [OUT_COUNT_W-1:0]  node_count;
  logic                    in_accept;

  assign status     = m_axis_tdata[OUT_STATUS_W-1:0];
  assign owner      = m_axis_tdata[OUT_OWNER_LO +: OUT_OWNER_W];
  assign node_count = m_axis_tdata[OUT_COUNT_LO +: OUT_COUNT_W];
  assign in_accept  = s_axis_tvalid && s_axis_tready;

  // one request in flight: busy straight after taking one
  `CHRL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_accept, !s_axis_tready)

  // a stalled result holds
  `CHRL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // failed requests carry no owner
  `CHRL_ASSERT_IMP(a_fail_no_owner, clk_i, rst_ni, m_axis_tvalid && (status != STAT_OK), owner == '0)

  // an empty ring reports no nodes, a full table reports all of them
  `CHRL_ASSERT_IMP(a_empty_count, clk_i, rst_ni, m_axis_tvalid && (status == STAT_EMPTY), node_count == '0)
  `CHRL_ASSERT_IMP(a_full_count, clk_i, rst_ni, m_axis_tvalid && (status == STAT_FULL), node_count == FULL_CNT)

endmodule

bind consistent_hash_ring_lookup chrl_checker #(
  .MAX_NODES (MAX_NODES)
) u_chrl_checker (.*);

`default_nettype wire

// ----- test/testbench.sv -----
// self-checking testbench for consistent_hash_ring_lookup: directed table, then random traffic
// predicts every reply with its own sorted ring model; depends on chrl_pkg and the rtl only
`default_nettype none

module testbench;
  import chrl_pkg::*;

  localparam int unsigned RING_SLOTS     = MAX_NODES_DEF;
  localparam int unsigned DIRECTED_COUNT = 25;
  localparam int unsigned RANDOM_ITEMS   = 625;
  localparam int unsigned QUIET_TAIL     = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = MAX_NODES_DEF + 8;
  localparam logic [IN_HASH_W-1:0] HASH_TOP = '1;
  localparam logic [IN_HASH_W-1:0] HASH_MID = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [OUT_STATUS_W-1:0] status;
    logic [OUT_OWNER_W-1:0]  owner;
    logic [OUT_COUNT_W-1:0]  count;
  } ring_reply_t;

  // one directed transaction; typed marks a reply written out by hand
  typedef struct packed {
    logic                    op;
    logic [IN_HASH_W-1:0]    hash;
    logic [IN_TAG_W-1:0]     tag;
    logic                    typed;
    logic [OUT_STATUS_W-1:0] status;
    logic [OUT_OWNER_W-1:0]  owner;
    logic [OUT_COUNT_W-1:0]  count;
  } ring_stim_t;

  localparam ring_stim_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // empty ring, both hash extremes
    '{OP_LOOKUP, 64'h0,     8'h00, 1'b1, STAT_EMPTY, 8'h00, 5'd0},
    '{OP_LOOKUP, HASH_TOP,  8'hFF, 1'b1, STAT_EMPTY, 8'h00, 5'd0},
    '{OP_JOIN,   HASH_MID,  8'h11, 1'b1, STAT_OK,    8'h00, 5'd1},
    // key above every hash wraps to the first entry
    '{OP_LOOKUP, HASH_MID + 64'd1, 8'h00, 1'b1, STAT_OK, 8'h11, 5'd1},
    '{OP_JOIN,   64'h0,     8'h00, 1'b1, STAT_OK,    8'h00, 5'd2},
    '{OP_JOIN,   HASH_TOP,  8'hFF, 1'b1, STAT_OK,    8'h00, 5'd3},
    '{OP_LOOKUP, 64'h0,     8'h00, 1'b1, STAT_OK,    8'h00, 5'd3},
    '{OP_LOOKUP, 64'h1,     8'h00, 1'b1, STAT_OK,    8'h11, 5'd3},
    '{OP_LOOKUP, HASH_TOP,  8'h00, 1'b1, STAT_OK,    8'hFF, 5'd3},
    // equal hash: newest node wins
    '{OP_JOIN,   HASH_MID,  8'h5A, 1'b1, STAT_OK,    8'h00, 5'd4},
    '{OP_LOOKUP, HASH_MID,  8'h00, 1'b1, STAT_OK,    8'h5A, 5'd4},
    // fill up the table, replies from the predictor
    '{OP_JOIN,   HASH_MID,               8'hA5, 1'b0, STAT_OK, 8'h00, 5'd0},
    '{OP_JOIN,   64'h0,                  8'h3C, 1'b0, STAT_OK, 8'h00, 5'd0},
    '{OP_LOOKUP, 64'h0,                  8'h00, 1'b0, STAT_OK, 8'h00, 5'd0},
    '{OP_JOIN,   64'h1,                  8'h01, 1'b0, STAT_OK, 8'h00, 5'd0},
    '{OP_JOIN,   64'hFFFF_FFFF_FFFF_FFFE, 8'hFE, 1'b0, STAT_OK, 8'h00, 5'd0},
    '{OP_JOIN,   64'h7FFF_FFFF_FFFF_FFFF, 8'h7F, 1'b0, STAT_OK, 8'h00, 5'd0},
    '{OP_JOIN,   64'h0123_4567_89AB_CDEF, 8'h80, 1'b0, STAT_OK, 8'h00, 5'd0},
    '{OP_JOIN,   64'hFEDC_BA98_7654_3210, 8'h40, 1'b0, STAT_OK, 8'h00, 5'd0},
    '{OP_JOIN,   64'hAAAA_AAAA_AAAA_AAAA, 8'hAA, 1'b0, STAT_OK, 8'h00, 5'd0},
    '{OP_JOIN,   64'h5555_5555_5555_5555, 8'h55, 1'b0, STAT_OK, 8'h00, 5'd0},
    '{OP_JOIN,   HASH_TOP,               8'hC3, 1'b0, STAT_OK, 8'h00, 5'd0},
    '{OP_JOIN,   HASH_MID,               8'h0F, 1'b0, STAT_OK, 8'h00, 5'd0},
    '{OP_JOIN,   64'h0000_0000_FFFF_FFFF, 8'h24, 1'b0, STAT_OK, 8'h00, 5'd0},
    // table full: join refused, ring unchanged
    '{OP_JOIN,   64'h1234,  8'h99, 1'b1, STAT_FULL,  8'h00, 5'd16}
  };

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_DATA_W-1:0]    s_axis_tdata  = '0;
  logic [IN_USER_W-1:0]    s_axis_tuser  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;

  // shadow copy of the ring, kept sorted like the block's table
  logic [IN_HASH_W-1:0]    ring_hash [RING_SLOTS];
  logic [IN_TAG_W-1:0]     ring_tag  [RING_SLOTS];
  int                      ring_count = 0;

  ring_reply_t             replies_due [$];
  int                      error_count = 0;
  int                      idle_pct    = 0;
  int                      rx_stall_left = 0;
  int                      quiet_cycles  = 0;

  consistent_hash_ring_lookup u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // apply one join or lookup to the shadow ring and return the reply it owes
  function automatic ring_reply_t predict_ring_reply(input logic op,
                                                     input logic [IN_HASH_W-1:0] hash,
                                                     input logic [IN_TAG_W-1:0] tag);
    ring_reply_t reply;
    int          pos;
    int          i;
    reply = '{status: STAT_OK, owner: '0, count: '0};
    // successor slot: lowest index whose hash is not below the key
    pos = ring_count;
    for (i = ring_count - 1; i >= 0; i--) begin
      if (ring_hash[i] >= hash) pos = i;
    end
    if (op == OP_JOIN) begin
      if (ring_count >= RING_SLOTS) begin
        reply.status = STAT_FULL;
      end else begin
        for (i = ring_count; i > pos; i--) begin
          ring_hash[i] = ring_hash[i-1];
          ring_tag[i]  = ring_tag[i-1];
        end
        ring_hash[pos] = hash;
        ring_tag[pos]  = tag;
        ring_count++;
      end
    end else if (ring_count == 0) begin
      reply.status = STAT_EMPTY;
    end else begin
      reply.owner = ring_tag[(pos == ring_count) ? 0 : pos];
    end
    reply.count = ring_count[OUT_COUNT_W-1:0];
    return reply;
  endfunction

  // offer one request, hold it until taken, then maybe leave a gap
  task automatic send_request(input logic op, input logic [IN_HASH_W-1:0] hash,
                              input logic [IN_TAG_W-1:0] tag, input logic typed,
                              input ring_reply_t typed_reply);
    ring_reply_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tag, hash};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = predict_ring_reply(op, hash, tag);
    replies_due.push_back(typed ? typed_reply : predicted);
    if ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // pick a lookup key near the stored hashes most of the time
  function automatic logic [IN_HASH_W-1:0] pick_key();
    int sel;
    int idx;
    sel = $urandom_range(0, 9);
    idx = (ring_count > 0) ? $urandom_range(0, ring_count - 1) : 0;
    if (ring_count > 0 && sel < 4) return ring_hash[idx];
    if (ring_count > 0 && sel < 5) return ring_hash[idx] + 64'd1;
    if (ring_count > 0 && sel < 6) return ring_hash[idx] - 64'd1;
    if (sel == 6) return ($urandom_range(0, 1) != 0) ? HASH_TOP : '0;
    return {$urandom, $urandom};
  endfunction

  // receive side: check each reply, stall in random bursts
  always @(posedge clk_i) begin
    ring_reply_t due;
    ring_reply_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[0 +: OUT_STATUS_W];
      got.owner  = m_axis_tdata[OUT_OWNER_LO +: OUT_OWNER_W];
      got.count  = m_axis_tdata[OUT_COUNT_LO +: OUT_COUNT_W];
      if (replies_due.size() == 0) begin
        $display("%0t: reply with none outstanding, expected nothing, got %h",
                 $time, m_axis_tdata);
        error_count++;
      end else begin
        due = replies_due.pop_front();
        if (got.status !== due.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, due.status, got.status);
          error_count++;
        end
        if (got.owner !== due.owner) begin
          $display("%0t: owner_tag mismatch, expected %h, got %h",
                   $time, due.owner, got.owner);
          error_count++;
        end
        if (got.count !== due.count) begin
          $display("%0t: node_count mismatch, expected %0d, got %0d",
                   $time, due.count, got.count);
          error_count++;
        end
      end
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      m_axis_tready <= 1'b0;
      rx_stall_left <= $urandom_range(0, 4);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog: too long without any transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int          n;
    logic        op;
    ring_reply_t hand_reply;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 20;
    for (n = 0; n < DIRECTED_COUNT; n++) begin
      hand_reply = '{status: DIRECTED_ROWS[n].status, owner: DIRECTED_ROWS[n].owner,
                     count: DIRECTED_ROWS[n].count};
      send_request(DIRECTED_ROWS[n].op, DIRECTED_ROWS[n].hash, DIRECTED_ROWS[n].tag,
                   DIRECTED_ROWS[n].typed, hand_reply);
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // idling changes every hundred items, none at all near the end
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 35;
        endcase
      end
      if (n >= RANDOM_ITEMS - QUIET_TAIL) idle_pct = 0;
      // hold off once until the block has nothing outstanding
      if (n == RANDOM_ITEMS / 2) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (replies_due.size() != 0);
      end
      op = ($urandom_range(0, 99) < 15) ? OP_JOIN : OP_LOOKUP;
      send_request(op, (op == OP_JOIN) ? {$urandom, $urandom} : pick_key(),
                   IN_TAG_W'($urandom_range(0, 255)), 1'b0, '0);
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (replies_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && replies_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
